// ===== sv/lpf_pkg.sv =====
// Shared types, constants and helpers for the line pattern finder.
// No dependencies; every other file of the block imports this package.
package lpf_pkg;

	localparam int unsigned PAT_CHARS = 20;  // characters held by the pattern registers
	localparam int unsigned LEN_W     = 5;   // width of the pattern_length register
	localparam int unsigned REG_IDX_W = 3;   // width of the configuration register index
	localparam int unsigned CFG_DATA_W = 64;

	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_LOW_A   = 8'd97;
	localparam logic [7:0] CH_LOW_Z   = 8'd122;
	localparam logic [7:0] CH_UP_A    = 8'd65;
	localparam logic [7:0] CH_UP_Z    = 8'd90;
	localparam logic [7:0] CASE_DIFF  = 8'd32;

	typedef enum logic [1:0] {
		MODE_SUBSTR = 2'd0,
		MODE_PREFIX = 2'd1,
		MODE_SUFFIX = 2'd2,
		MODE_WORD   = 2'd3
	} mode_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PAT_LOW   = 3'd0,
		REG_PAT_MID   = 3'd1,
		REG_PAT_HIGH  = 3'd2,
		REG_PAT_LEN   = 3'd3,
		REG_FOLD_CASE = 3'd4,
		REG_LETTERS   = 3'd5,
		REG_MODE      = 3'd6
	} reg_idx_t;

	typedef logic [PAT_CHARS-1:0][7:0] pattern_t;

	// Current configuration as seen by the datapath
	typedef struct packed {
		pattern_t         pattern;
		logic [LEN_W-1:0] pattern_length;
		logic             fold_case;
		logic             letters_only;
		mode_t            match_mode;
	} cfg_t;

	// Window compare result for the byte being shifted in
	typedef struct packed {
		logic cand;        // pattern ends at the newest kept byte
		logic word_start;  // byte before the candidate is a space or line start
	} match_t;

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= CH_UP_A) && (c <= CH_UP_Z);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return is_upper(c) || ((c >= CH_LOW_A) && (c <= CH_LOW_Z));
	endfunction

	function automatic logic [7:0] fold(input logic [7:0] c, input logic en);
		return (en && is_upper(c)) ? c + CASE_DIFF : c;
	endfunction

endpackage

// ===== sv/lpf_channels.sv =====
// Valid/ready channel interfaces of the line pattern finder: text bytes,
// per-line results and configuration writes. Depends on lpf_pkg.
interface lpf_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	modport source (output valid, char_code, input ready);
	modport sink   (input valid, char_code, output ready);
endinterface

interface lpf_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] line_number;
	logic [7:0]  match_count;
	logic        line_matched;
	modport source (output valid, line_number, match_count, line_matched, input ready);
	modport sink   (input valid, line_number, match_count, line_matched, output ready);
endinterface

interface lpf_cfg_if import lpf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [REG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/lpf_cfg_regs.sv =====
// Configuration register file of the line pattern finder.
// Depends on lpf_pkg and lpf_cfg_if.
module lpf_cfg_regs import lpf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	lpf_cfg_if.sink   cfg,
	output cfg_t      cfg_cur
);

	logic [63:0]      pat_low_q;
	logic [63:0]      pat_mid_q;
	logic [31:0]      pat_high_q;
	logic [LEN_W-1:0] pat_len_q;
	logic             fold_case_q;
	logic             letters_only_q;
	mode_t            mode_q;

	assign cfg.ready = 1'b1;

	// Register writes, one per beat; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q      <= '0;
			pat_mid_q      <= '0;
			pat_high_q     <= '0;
			pat_len_q      <= LEN_W'(1);
			fold_case_q    <= 1'b0;
			letters_only_q <= 1'b0;
			mode_q         <= MODE_SUBSTR;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_PAT_LOW:   pat_low_q      <= cfg.data;
				REG_PAT_MID:   pat_mid_q      <= cfg.data;
				REG_PAT_HIGH:  pat_high_q     <= cfg.data[31:0];
				REG_PAT_LEN:   pat_len_q      <= cfg.data[LEN_W-1:0];
				REG_FOLD_CASE: fold_case_q    <= cfg.data[0];
				REG_LETTERS:   letters_only_q <= cfg.data[0];
				REG_MODE:      mode_q         <= mode_t'(cfg.data[1:0]);
				default: ;
			endcase
		end
	end

	assign cfg_cur.pattern        = {pat_high_q, pat_mid_q, pat_low_q};
	assign cfg_cur.pattern_length = pat_len_q;
	assign cfg_cur.fold_case      = fold_case_q;
	assign cfg_cur.letters_only   = letters_only_q;
	assign cfg_cur.match_mode     = mode_q;

endmodule

// ===== sv/lpf_matcher.sv =====
// Sliding character window and parallel pattern compare.
// Depends on lpf_pkg.
module lpf_matcher import lpf_pkg::*; #(
	parameter int unsigned PATTERN_MAX = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg_cur,
	input  logic [7:0] char_code,
	input  logic       shift,    // kept byte enters the window
	input  logic       clear,    // line end
	output match_t     match
);

	localparam int unsigned DEPTH = PATTERN_MAX + 1;
	localparam int unsigned FW    = $clog2(DEPTH + 1);
	localparam int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0]       win_q [DEPTH];
	logic [7:0]       win_nxt [DEPTH];
	logic [FW-1:0]    fill_q;
	logic [FW-1:0]    fill_nxt;
	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] fill_ext;
	logic [PATTERN_MAX-1:0] pos_eq;
	logic [LEN_W-1:0] pidx [PATTERN_MAX];
	logic [7:0]       pchr [PATTERN_MAX];

	// Effective length: zero acts as one, clamp to the window
	always_comb begin
		len = cfg_cur.pattern_length;
		if (len == '0)
			len = LEN_W'(1);
		if (len > LEN_W'(PATTERN_MAX))
			len = LEN_W'(PATTERN_MAX);
	end

	// Window after the shift
	always_comb begin
		win_nxt[0] = char_code;
		for (int j = 1; j < DEPTH; j++)
			win_nxt[j] = win_q[j-1];
		fill_nxt = (fill_q != FW'(DEPTH)) ? fill_q + FW'(1) : fill_q;
		fill_ext = LEN_W'(fill_nxt);
	end

	// Window slot j holds pattern character len-1-j
	always_comb begin
		for (int j = 0; j < PATTERN_MAX; j++) begin
			pidx[j]   = len - LEN_W'(1) - LEN_W'(j);
			pchr[j]   = cfg_cur.pattern[pidx[j]];
			pos_eq[j] = (LEN_W'(j) >= len) ||
				(fold(win_nxt[j], cfg_cur.fold_case) == fold(pchr[j], cfg_cur.fold_case));
		end
	end

	assign match.cand       = (fill_ext >= len) && (&pos_eq);
	assign match.word_start = (fill_ext > len) ? (win_nxt[len[IW-1:0]] == CH_SPACE) : 1'b1;

	// Window data, no reset needed: fill gates every read
	always_ff @(posedge clk) begin
		if (shift)
			win_q <= win_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fill_q <= '0;
		else if (clear)
			fill_q <= '0;
		else if (shift)
			fill_q <= fill_nxt;
	end

endmodule

// ===== sv/line_pattern_finder.sv =====
// Line pattern finder: counts pattern occurrences in each text line.
// Channels: chars (sink) takes one text byte per beat; byte 10 ends a line.
//   results (source) gives one beat per line end: line number, match count and
//   a matched flag. cfg (sink) writes one configuration register per beat; it
//   is always ready and is to be written only while the block is idle.
// Throughput: one byte per cycle. A byte is registered on acceptance and its
//   window compare and counter update work from that input register.
// Result: a line's result is registered when its newline leaves the input register.
// Stall: a result waits in the output register. Bytes that are not newlines
//   keep flowing; a newline holds in the input register until the output
//   register is free, and chars.ready drops while it waits.
// Reset: arst_n clears the line number, the match count, the window fill and
//   all valid flags; registers return to pattern length 1, substring mode.
// Depends on lpf_pkg, lpf_channels, lpf_cfg_regs and lpf_matcher.
module line_pattern_finder import lpf_pkg::*; #(
	parameter int unsigned PATTERN_MAX      = 20,
	parameter int unsigned LINE_NUMBER_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	lpf_char_if.sink      chars,
	lpf_result_if.source  results,
	lpf_cfg_if.sink       cfg
);

	localparam int unsigned LW = LINE_NUMBER_BITS + 16;

	cfg_t                        cfg_cur;
	match_t                      match;
	logic                        valid_s1;
	logic [7:0]                  char_s1;
	logic                        slot_free;
	logic                        is_nl;
	logic                        proc;
	logic                        kept;
	logic                        sp_end;
	logic                        hit_res;
	logic                        hit_new;
	logic                        pend_new;
	logic [8:0]                  cnt_sum;
	logic [7:0]                  cnt_nxt;
	logic                        pending_q;
	logic [7:0]                  count_q;
	logic [LINE_NUMBER_BITS-1:0] line_q;
	logic [LW-1:0]               line_wide;
	logic                        out_valid_q;
	logic [15:0]                 out_line_q;
	logic [7:0]                  out_count_q;

	lpf_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_cur (cfg_cur)
	);

	lpf_matcher #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_cur   (cfg_cur),
		.char_code (char_s1),
		.shift     (proc && kept),
		.clear     (proc && is_nl),
		.match     (match)
	);

	// Input handshake: a newline only moves on when the result slot is free
	assign slot_free   = !out_valid_q || results.ready;
	assign is_nl       = (char_s1 == CH_NEWLINE);
	assign proc        = valid_s1 && (!is_nl || slot_free);
	assign chars.ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (chars.ready)
			valid_s1 <= chars.valid;
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready)
			char_s1 <= chars.char_code;
	end

	// Filter, pending resolution and new candidate
	always_comb begin
		kept = !is_nl &&
			!(cfg_cur.letters_only && !is_letter(char_s1) && (char_s1 != CH_SPACE));
		sp_end = is_nl || (char_s1 == CH_SPACE);
		hit_res = 1'b0;
		if (pending_q) begin
			unique case (cfg_cur.match_mode)
				MODE_SUBSTR: hit_res = 1'b1;
				MODE_PREFIX: hit_res = !sp_end;
				MODE_SUFFIX,
				MODE_WORD:   hit_res = sp_end;
				default:     hit_res = 1'b0;
			endcase
		end
		hit_new  = 1'b0;
		pend_new = 1'b0;
		if (kept && match.cand) begin
			unique case (cfg_cur.match_mode)
				MODE_SUBSTR: hit_new  = 1'b1;
				MODE_SUFFIX: pend_new = !match.word_start;
				MODE_PREFIX,
				MODE_WORD:   pend_new = match.word_start;
				default:     pend_new = 1'b0;
			endcase
		end
		cnt_sum = 9'(count_q) + 9'(hit_res) + 9'(hit_new);
		cnt_nxt = cnt_sum[8] ? 8'hFF : cnt_sum[7:0];
	end

	// Per-line counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			count_q   <= '0;
			line_q    <= '0;
		end else if (proc) begin
			if (is_nl) begin
				pending_q <= 1'b0;
				count_q   <= '0;
				if (line_q != '1)
					line_q <= line_q + LINE_NUMBER_BITS'(1);
			end else if (kept) begin
				pending_q <= pend_new;
				count_q   <= cnt_nxt;
			end
		end
	end

	// Result register
	assign line_wide = LW'(line_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (proc && is_nl)
			out_valid_q <= 1'b1;
		else if (results.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (proc && is_nl) begin
			out_line_q  <= (line_wide > LW'(16'hFFFF)) ? 16'hFFFF : line_wide[15:0];
			out_count_q <= cnt_nxt;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.line_number  = out_line_q;
	assign results.match_count  = out_count_q;
	assign results.line_matched = (out_count_q != 8'd0);

endmodule

// ===== dv/lpf_checker.sv =====
`timescale 1ns / 100ps
// Line report checker for line_pattern_finder: watches the byte, result and register
// channels, predicts each line's report and compares it beat by beat.
// Depends on lpf_pkg and lpf_channels.
module lpf_checker import lpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	lpf_char_if         chars,
	lpf_result_if       results,
	lpf_cfg_if          cfg,
	output int unsigned mismatches,
	output int unsigned lines_pending,
	output int unsigned lines_checked
);

	localparam int unsigned WIN_DEPTH  = PAT_CHARS + 1;

	typedef struct packed {
		logic [15:0] line_number;
		logic [7:0]  match_count;
		logic        line_matched;
	} line_report_t;

	line_report_t expected_reports[$];

	// Shadow of the configuration registers
	logic [PAT_CHARS*8-1:0] pat_flat;
	logic [LEN_W-1:0]       len_reg;
	logic                   fold_en;
	logic                   letters_en;
	mode_t                  mode;

	// Predicted per-line state
	logic [7:0]  window [WIN_DEPTH];
	int unsigned fill;
	logic [15:0] line_no;
	logic [7:0]  hits;
	logic        awaiting_follow;  // candidate waits for the next kept byte or the line end
	int unsigned errs;
	int unsigned checked;

	function automatic logic [7:0] case_key(input logic [7:0] c);
		if (fold_en && c >= CH_UP_A && c <= CH_UP_Z)
			return c + CASE_DIFF;
		return c;
	endfunction

	function automatic void bump_hits();
		if (hits != 8'hFF)
			hits++;
	endfunction

	// Resolve a waiting candidate; follow_gap means a space or the line end follows
	function automatic void settle_candidate(input logic follow_gap);
		logic hit;
		if (!awaiting_follow)
			return;
		case (mode)
			MODE_SUBSTR: hit = 1'b1;
			MODE_PREFIX: hit = !follow_gap;
			default:     hit = follow_gap;
		endcase
		if (hit)
			bump_hits();
		awaiting_follow = 1'b0;
	endfunction

	function automatic void clear_line();
		foreach (window[i])
			window[i] = 8'h00;
		fill = 0;
		hits = 8'h00;
		awaiting_follow = 1'b0;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			errs++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		line_report_t got;
		line_report_t want;
		logic [7:0]   c;
		int unsigned  len;
		logic         same;
		logic         ws;
		if (!arst_n) begin
			pat_flat = '0;
			len_reg = LEN_W'(1);
			fold_en = 1'b0;
			letters_en = 1'b0;
			mode = MODE_SUBSTR;
			line_no = 16'd0;
			clear_line();
			expected_reports.delete();
			errs = 0;
			checked = 0;
		end else begin
			// Register writes
			if (cfg.valid && cfg.ready) begin
				case (reg_idx_t'(cfg.index))
					REG_PAT_LOW:   pat_flat[63:0] = cfg.data;
					REG_PAT_MID:   pat_flat[127:64] = cfg.data;
					REG_PAT_HIGH:  pat_flat[159:128] = cfg.data[31:0];
					REG_PAT_LEN:   len_reg = cfg.data[LEN_W-1:0];
					REG_FOLD_CASE: fold_en = cfg.data[0];
					REG_LETTERS:   letters_en = cfg.data[0];
					REG_MODE:      mode = mode_t'(cfg.data[1:0]);
					default: ;
				endcase
			end

			// Result beats against the oldest expected report
			if (results.valid && results.ready) begin
				got = {results.line_number, results.match_count, results.line_matched};
				if (expected_reports.size() == 0) begin
					errs++;
					$error("report for line %0d arrived with none pending",
						got.line_number);
				end else begin
					want = expected_reports.pop_front();
					checked++;
					check_field("line_number", want.line_number, got.line_number);
					check_field("match_count", 16'(want.match_count), 16'(got.match_count));
					check_field("line_matched", 16'(want.line_matched),
						16'(got.line_matched));
				end
			end

			// Text bytes
			if (chars.valid && chars.ready) begin
				c = chars.char_code;
				if (c == CH_NEWLINE) begin
					settle_candidate(1'b1);
					expected_reports.push_back({line_no, hits, hits != 8'h00});
					if (line_no != 16'hFFFF)
						line_no++;
					clear_line();
				end else if (!letters_en || c == CH_SPACE
						|| (c >= CH_LOW_A && c <= CH_LOW_Z)
						|| (c >= CH_UP_A && c <= CH_UP_Z)) begin
					settle_candidate(c == CH_SPACE);
					for (int i = WIN_DEPTH - 1; i > 0; i--)
						window[i] = window[i-1];
					window[0] = c;
					if (fill < WIN_DEPTH)
						fill++;

					// Compare the newest len kept bytes with the pattern
					len = (len_reg == 0) ? 1 : (len_reg > PAT_CHARS) ? PAT_CHARS : len_reg;
					if (fill >= len) begin
						same = 1'b1;
						for (int k = 0; k < len; k++)
							if (case_key(window[len-1-k]) != case_key(pat_flat[8*k +: 8]))
								same = 1'b0;
						if (same) begin
							ws = (fill > len) ? (window[len] == CH_SPACE) : 1'b1;
							case (mode)
								MODE_SUBSTR: bump_hits();
								MODE_SUFFIX: if (!ws) awaiting_follow = 1'b1;
								default:     if (ws) awaiting_follow = 1'b1;
							endcase
						end
					end
				end
			end
		end
		mismatches <= errs;
		lines_pending <= expected_reports.size();
		lines_checked <= checked;
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for line_pattern_finder: clock, reset, text and register stimulus,
// result back-pressure, a stall watchdog and the verdict.
// Depends on lpf_pkg, lpf_channels, line_pattern_finder and lpf_checker.
module tb_top;
	import lpf_pkg::*;

	localparam int unsigned TEXT_BYTES    = 1200;
	localparam int unsigned SETTLE_CYCLES = 4;     // margin for the last byte to pass the compare
	localparam int unsigned STALL_LIMIT   = 2000;  // cycles with no beat on any channel

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lpf_char_if   chars();
	lpf_result_if results();
	lpf_cfg_if    cfg();

	int unsigned mismatches;
	int unsigned lines_pending;
	int unsigned lines_checked;
	int unsigned bytes_sent = 0;
	int unsigned settings_loaded = 0;
	int unsigned burst_left = 0;
	int unsigned quiet_cycles = 0;

	// Pattern in force, for building text that hits it
	logic [PAT_CHARS*8-1:0] cur_pat = '0;
	int unsigned            cur_len = 1;

	line_pattern_finder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars),
		.results (results),
		.cfg     (cfg)
	);

	lpf_checker line_report_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.chars         (chars),
		.results       (results),
		.cfg           (cfg),
		.mismatches    (mismatches),
		.lines_pending (lines_pending),
		.lines_checked (lines_checked)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Result back-pressure: short random runs, long stalls, long open stretches
	initial begin
		int unsigned run_len;
		int unsigned stall_len;
		results.ready = 1'b0;
		run_len = 0;
		stall_len = 0;
		forever begin
			@(posedge clk);
			if (run_len == 0 && stall_len == 0) begin
				case ($urandom_range(0, 7))
					0: begin
						run_len = 150;
						stall_len = 0;
					end
					1: begin
						run_len = 1;
						stall_len = $urandom_range(10, 30);
					end
					default: begin
						run_len = $urandom_range(1, 6);
						stall_len = $urandom_range(0, 4);
					end
				endcase
			end
			if (run_len != 0) begin
				results.ready <= 1'b1;
				run_len--;
			end else begin
				results.ready <= 1'b0;
				stall_len--;
			end
		end
	end

	// Watchdog on cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (chars.valid && chars.ready) || (results.valid && results.ready)
				|| (cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One text byte per beat, sent in bursts with random gaps between them
	task automatic send_byte(input logic [7:0] c);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				chars.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
		end
		chars.valid <= 1'b1;
		chars.char_code <= c;
		do @(posedge clk); while (!chars.ready);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Leaves valid high so back-to-back writes keep one assignment per step
	task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
	endtask

	// Block goes idle: every report back, last byte through the compare
	task automatic wait_settled();
		chars.valid <= 1'b0;
		do @(posedge clk); while (lines_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes every register; unused upper data bits carry random junk
	task automatic load_setting(input logic [PAT_CHARS*8-1:0] pat,
			input logic [LEN_W-1:0] len_code, input logic fold, input logic letters,
			input mode_t m);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		write_reg(REG_PAT_LOW, pat[63:0]);
		write_reg(REG_PAT_MID, pat[127:64]);
		write_reg(REG_PAT_HIGH, {junk[63:32], pat[159:128]});
		write_reg(REG_PAT_LEN, {junk[63:LEN_W], len_code});
		write_reg(REG_FOLD_CASE, {junk[63:1], fold});
		write_reg(REG_LETTERS, {junk[62:0], letters});
		write_reg(REG_MODE, {junk[63:2], m});
		cfg.valid <= 1'b0;
		cur_pat = pat;
		cur_len = (len_code == 0) ? 1 : (len_code > PAT_CHARS) ? PAT_CHARS : len_code;
		settings_loaded++;
	endtask

	// Pattern string in the low characters, random bytes above it
	function automatic logic [PAT_CHARS*8-1:0] pattern_of(input string s);
		logic [PAT_CHARS*8-1:0] flat;
		for (int k = 0; k < PAT_CHARS; k++)
			flat[8*k +: 8] = (k < s.len()) ? s[k] : 8'($urandom);
		return flat;
	endfunction

	// Small alphabet so patterns and text collide often
	function automatic logic [7:0] pick_letter();
		case ($urandom_range(0, 9))
			0, 1, 2: return "a";
			3, 4:    return "b";
			5, 6:    return "A";
			7:       return "B";
			default: return 8'($urandom_range(CH_LOW_A, CH_LOW_Z));
		endcase
	endfunction

	function automatic logic [7:0] stray_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == CH_NEWLINE);
		return c;
	endfunction

	// A line of words: copies of the pattern (case flipped, padded or cut short),
	// random letter runs and stray bytes, split by spaces or junk
	task automatic send_random_line(input bit close);
		int unsigned words;
		int unsigned sel;
		int unsigned n;
		logic [7:0]  c;
		words = $urandom_range(0, 7);
		for (int w = 0; w < words; w++) begin
			if (w != 0 || $urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 9))
					0, 1: begin
						send_byte(CH_SPACE);
						send_byte(CH_SPACE);
					end
					2:       send_byte(stray_byte());
					default: send_byte(CH_SPACE);
				endcase
			end
			sel = $urandom_range(0, 9);
			if (sel <= 4 || sel == 8) begin
				if (sel == 4)
					send_byte(pick_letter());
				n = (sel == 8 && cur_len > 1) ? cur_len - 1 : cur_len;
				for (int k = 0; k < n; k++) begin
					c = cur_pat[8*k +: 8];
					if ((c | 8'h20) >= CH_LOW_A && (c | 8'h20) <= CH_LOW_Z
							&& $urandom_range(0, 4) == 0)
						c ^= 8'h20;
					send_byte(c);
				end
				if (sel == 3)
					send_byte(pick_letter());
			end else if (sel == 9) begin
				repeat ($urandom_range(1, 3)) send_byte(stray_byte());
			end else begin
				repeat ($urandom_range(1, 5)) send_byte(pick_letter());
			end
		end
		if ($urandom_range(0, 3) == 0)
			send_byte(CH_SPACE);
		if (close)
			send_byte(CH_NEWLINE);
	endtask

	initial begin
		logic [PAT_CHARS*8-1:0] pat;
		logic [LEN_W-1:0]       len_code;
		logic                   fold;
		int unsigned            lines;
		chars.valid = 1'b0;
		chars.char_code = 8'h00;
		cfg.valid = 1'b0;
		cfg.index = REG_PAT_LOW;
		cfg.data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset pattern is a single zero byte; extremes of the byte range
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_NEWLINE);

		// Zero length acts as one character
		wait_settled();
		load_setting(pattern_of("ab"), 5'd0, 1'b0, 1'b0, MODE_SUBSTR);
		send_text("aA\n");

		// Whole word, folded, punctuation dropped
		wait_settled();
		load_setting(pattern_of("ab"), 5'd2, 1'b1, 1'b1, MODE_WORD);
		send_text("A-b ab\n");

		// Word prefix
		wait_settled();
		load_setting(pattern_of("ab"), 5'd2, 1'b0, 1'b0, MODE_PREFIX);
		send_text("ab abc\n");

		// Word suffix; then a mode change while a candidate waits mid-line
		wait_settled();
		load_setting(pattern_of("ab"), 5'd2, 1'b0, 1'b0, MODE_SUFFIX);
		send_text("cab\ncab");
		wait_settled();
		write_reg(REG_MODE, {62'd0, MODE_SUBSTR});
		cfg.valid <= 1'b0;
		send_byte(CH_NEWLINE);

		// Count saturates on a long line; window fill saturates too
		wait_settled();
		load_setting(pattern_of("a"), 5'd1, 1'b0, 1'b0, MODE_SUBSTR);
		repeat (300) send_byte("a");
		send_byte(CH_NEWLINE);

		// Random settings and text; some phases end mid-line
		for (int phase = 0; bytes_sent < TEXT_BYTES; phase++) begin
			for (int k = 0; k < PAT_CHARS; k++)
				pat[8*k +: 8] = ($urandom_range(0, 9) < 8)
					? (($urandom_range(0, 9) == 0) ? CH_SPACE : pick_letter())
					: 8'($urandom);
			case ($urandom_range(0, 19))
				0:       len_code = 5'd0;
				1:       len_code = 5'($urandom_range(PAT_CHARS + 1, 31));
				2, 3, 4: len_code = 5'($urandom_range(5, PAT_CHARS));
				default: len_code = 5'($urandom_range(1, 4));
			endcase
			fold = 1'($urandom);
			// Longest pattern with folding, so full-length copies in the text hit
			if (phase == 0) begin
				len_code = 5'd31;
				fold = 1'b1;
			end
			wait_settled();
			load_setting(pat, len_code, fold, 1'($urandom), mode_t'($urandom_range(0, 3)));
			lines = $urandom_range(1, 8);
			for (int l = 0; l < lines; l++)
				send_random_line(l != lines - 1 || $urandom_range(0, 4) != 0);
		end

		wait_settled();
		$display("Checked %0d line reports from %0d text bytes under %0d register settings.",
			lines_checked, bytes_sent, settings_loaded);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/lpf_pkg.sv
sv/lpf_channels.sv
sv/lpf_cfg_regs.sv
sv/lpf_matcher.sv
sv/line_pattern_finder.sv
dv/lpf_checker.sv
dv/tb_top.sv
